### design/timing_wheel_task_scheduler_top_assert.svh
// assertion macros for the timing wheel scheduler
// expects clk and arst_n in the scope of the module that uses them
`ifndef TIMING_WHEEL_TASK_SCHEDULER_TOP_ASSERT_SVH
`define TIMING_WHEEL_TASK_SCHEDULER_TOP_ASSERT_SVH

// condition holds in the same cycle
`define TWTS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// condition holds in the following cycle
`define TWTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

### design/twts_pkg.sv
// shared types and codes for the timing wheel task scheduler
// no dependencies
package twts_pkg;

	localparam int ID_W      = 4;
	localparam int PERIOD_W  = 16;
	localparam int ELAPSED_W = 16;

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_ADD  = 1'b1
	} command_t;

	typedef struct packed {
		command_t            command;
		logic [ID_W-1:0]     task_id;
		logic [PERIOD_W-1:0] period;
	} request_t;

	typedef struct packed {
		logic [ID_W-1:0] fired_task;
		logic            last_fired;
	} result_t;

endpackage

### design/timing_wheel_task_scheduler_top.sv
// hashed timing wheel scheduler with an overflow list, one task memory
// depends on twts_pkg and timing_wheel_task_scheduler_top_assert.svh
//
//  channel   ports                       handshake
//  -------   -------------------------   -------------------------------------
//  command   start, request, busy        word taken when start high, busy low
//  result    result_valid, result        one word per strobe cycle, no stall
//
// an add never holds the block: the task entry is written at the accept edge
// a tick walks the task memory: the walk reads one
//   task entry per cycle through the single read port, through two pipeline
//   stages, then a flush state and the return to idle
// results leave at most one per cycle in ascending task index, last marked
// no clearing pass after reset: task valid bits live in flops, the entry
//   memory itself holds nothing that is read before an add writes it
// the receiver cannot stall, so busy is the only back pressure
module timing_wheel_task_scheduler_top import twts_pkg::*; #(
	parameter int WHEEL_SLOTS = 64,
	parameter int NUM_TASKS   = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  request_t request,
	output logic     busy,
	output logic     result_valid,
	output result_t  result
);

	localparam int SLOT_W = $clog2(WHEEL_SLOTS);
	localparam int TIDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int SUM_W  = PERIOD_W + 1;

	localparam logic [SUM_W-1:0]  WHEEL_SPAN = SUM_W'(WHEEL_SLOTS);
	localparam logic [SLOT_W:0]   SLOT_MOD   = (SLOT_W + 1)'(WHEEL_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(WHEEL_SLOTS - 1);
	localparam logic [TIDX_W-1:0] LAST_TASK  = TIDX_W'(NUM_TASKS - 1);

	// one memory word per task
	typedef struct packed {
		logic [PERIOD_W-1:0]  period;
		logic [ELAPSED_W-1:0] elapsed;
		logic                 in_ovf;
		logic [SLOT_W-1:0]    slot;
	} entry_t;

	// entry plus the overflow arithmetic done one stage early
	typedef struct packed {
		entry_t               ent;
		logic                 is_due;
		logic                 is_near;
		logic [ELAPSED_W-1:0] e_low;
		logic [SLOT_W-1:0]    ahead;
	} ovf_eval_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	// slot a given span ahead of a base slot, span below the wheel size
	function automatic logic [SLOT_W-1:0] slot_ahead(
		input logic [SLOT_W-1:0] base,
		input logic [SLOT_W-1:0] span
	);
		logic [SLOT_W:0] sum;
		sum = {1'b0, base} + {1'b0, span};
		if (sum >= SLOT_MOD) begin
			sum = sum - SLOT_MOD;
		end
		return sum[SLOT_W-1:0];
	endfunction

	state_t                 state_q;
	logic [SLOT_W-1:0]      pos_q;
	logic                   wrap_q;
	logic [TIDX_W-1:0]      rd_idx_q;
	logic                   rd_on_q;
	logic [NUM_TASKS-1:0]   task_valid_q;
	logic                   pend_valid_q;
	logic [TIDX_W-1:0]      pend_id_q;
	logic                   result_valid_q;
	result_t                result_q;

	logic                   valid_s1;
	logic [TIDX_W-1:0]      idx_s1;
	entry_t                 rd_data_s1;
	ovf_eval_t              eval_s1;

	logic                   valid_s2;
	logic [TIDX_W-1:0]      idx_s2;
	ovf_eval_t              eval_s2;

	entry_t                 mem [NUM_TASKS];
	logic                   mem_we;
	logic [TIDX_W-1:0]      mem_waddr;
	entry_t                 mem_wdata;

	logic                   accept;
	logic                   take_tick;
	logic                   take_add;
	logic [TIDX_W-1:0]      add_idx;
	entry_t                 add_entry;
	logic [SLOT_W-1:0]      pos_next;

	logic                   walk_fire;
	logic                   walk_write;
	entry_t                 walk_entry;

	// command decode
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign take_tick = accept && (request.command == CMD_TICK);
	// an add for a task index past the table is dropped
	assign take_add  = accept && (request.command == CMD_ADD) &&
		(int'(request.task_id) < NUM_TASKS);
	assign add_idx   = TIDX_W'(request.task_id);
	assign pos_next  = (pos_q == LAST_SLOT) ? '0 : pos_q + 1'b1;

	// placement of a fresh add: short periods land in the wheel, long ones overflow
	always_comb begin
		add_entry.period  = request.period;
		add_entry.elapsed = '0;
		add_entry.in_ovf  = ({1'b0, request.period} >= WHEEL_SPAN);
		add_entry.slot    = slot_ahead(pos_q, request.period[SLOT_W-1:0]);
	end

	// stage 1: overflow arithmetic on the entry just read
	always_comb begin
		logic [SUM_W-1:0] e;
		logic [SUM_W-1:0] per;
		logic [SUM_W-1:0] diff;
		e    = {1'b0, rd_data_s1.elapsed} + WHEEL_SPAN;
		per  = {1'b0, rd_data_s1.period};
		diff = per - e;
		eval_s1.ent     = rd_data_s1;
		eval_s1.is_due  = (e == per);
		// less than a full wheel of the period remains
		eval_s1.is_near = (e < per) && (diff < WHEEL_SPAN);
		eval_s1.e_low   = e[ELAPSED_W-1:0];
		eval_s1.ahead   = diff[SLOT_W-1:0];
	end

	// stage 2: overflow step on wrap, then the slot check and re-add
	always_comb begin
		walk_entry = eval_s2.ent;
		walk_fire  = 1'b0;
		walk_write = 1'b0;
		if (valid_s2 && task_valid_q[idx_s2]) begin
			if (wrap_q && walk_entry.in_ovf) begin
				walk_write = 1'b1;
				if (eval_s2.is_due) begin
					// fires straight from overflow and stays there
					walk_fire          = 1'b1;
					walk_entry.elapsed = '0;
				end else begin
					walk_entry.elapsed = eval_s2.e_low;
					if (eval_s2.is_near) begin
						// position is zero on wrap, so the slot is the span itself
						walk_entry.in_ovf = 1'b0;
						walk_entry.slot   = eval_s2.ahead;
					end
				end
			end
			if (!walk_entry.in_ovf && !walk_fire && (walk_entry.slot == pos_q)) begin
				walk_fire          = 1'b1;
				walk_write         = 1'b1;
				walk_entry.elapsed = '0;
				walk_entry.in_ovf  = ({1'b0, walk_entry.period} >= WHEEL_SPAN);
				walk_entry.slot    = slot_ahead(pos_q, walk_entry.period[SLOT_W-1:0]);
			end
		end
	end

	// one write port shared by adds (idle only) and the walk write-back
	always_comb begin
		if (take_add) begin
			mem_we    = 1'b1;
			mem_waddr = add_idx;
			mem_wdata = add_entry;
		end else begin
			mem_we    = walk_write;
			mem_waddr = idx_s2;
			mem_wdata = walk_entry;
		end
	end

	// task memory, registered read; each entry is read once per walk and written back at most once
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[rd_idx_q];
	end

	// walk pipeline payload
	always_ff @(posedge clk) begin
		idx_s1  <= rd_idx_q;
		idx_s2  <= idx_s1;
		eval_s2 <= eval_s1;
	end

	// control, valid bits and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			pos_q          <= '0;
			wrap_q         <= 1'b0;
			rd_idx_q       <= '0;
			rd_on_q        <= 1'b0;
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			task_valid_q   <= '0;
			pend_valid_q   <= 1'b0;
			pend_id_q      <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;
			valid_s1       <= rd_on_q;
			valid_s2       <= valid_s1;
			if (take_add) begin
				task_valid_q[add_idx] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take_tick) begin
						state_q  <= ST_WALK;
						pos_q    <= pos_next;
						wrap_q   <= (pos_next == '0);
						rd_idx_q <= '0;
						rd_on_q  <= 1'b1;
					end
				end
				ST_WALK: begin
					if (rd_on_q) begin
						if (rd_idx_q == LAST_TASK) begin
							rd_on_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
					// hold one fired task back so the final one can be marked
					if (walk_fire) begin
						if (pend_valid_q) begin
							result_valid_q      <= 1'b1;
							result_q.fired_task <= ID_W'(pend_id_q);
							result_q.last_fired <= 1'b0;
						end
						pend_valid_q <= 1'b1;
						pend_id_q    <= idx_s2;
					end
					if (valid_s2 && (idx_s2 == LAST_TASK)) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (pend_valid_q) begin
						result_valid_q      <= 1'b1;
						result_q.fired_task <= ID_W'(pend_id_q);
						result_q.last_fired <= 1'b1;
					end
					pend_valid_q <= 1'b0;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`include "timing_wheel_task_scheduler_top_assert.svh"

	// an add never holds the block
	`TWTS_ASSERT_NEXT(a_add_one_cycle, take_add, !busy)
	// a tick always starts a walk
	`TWTS_ASSERT_NEXT(a_tick_walks, take_tick, busy)
	// a result word only comes out of a walk
	`TWTS_ASSERT_NOW(a_result_from_walk, result_valid, $past(busy))
	// nothing follows the word marked last
	`TWTS_ASSERT_NEXT(a_last_ends, result_valid && result.last_fired, !result_valid)

endmodule

### verif/timing_wheel_task_scheduler_checker.sv
// scoreboard for the timing wheel scheduler: predicts fired tasks and checks results
// depends on twts_pkg for the command and result word types
module timing_wheel_task_scheduler_checker import twts_pkg::*; #(
	parameter int WHEEL_SLOTS = 64,
	parameter int NUM_TASKS   = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  request_t request,
	input  logic     result_valid,
	input  result_t  result,
	output int       fail_count,
	output int       fires_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SHOWN_MISMATCHES = 10;

	// shadow copy of the wheel and the task table
	int unsigned wheel_pos;
	bit          task_live     [NUM_TASKS];
	int unsigned task_period   [NUM_TASKS];
	int unsigned task_elapsed  [NUM_TASKS];
	bit          task_parked   [NUM_TASKS];
	int unsigned task_slot_at  [NUM_TASKS];
	result_t     fire_queue    [$];

	function automatic void place_task(int unsigned t, int unsigned span);
		if (span >= WHEEL_SLOTS) begin
			task_parked[t] = 1'b1;
		end else begin
			task_parked[t]  = 1'b0;
			task_slot_at[t] = (wheel_pos + span) % WHEEL_SLOTS;
		end
	endfunction

	// applies one accepted command word and queues the fires it causes
	function automatic void predict_fires(request_t word);
		bit          fired [NUM_TASKS];
		int unsigned span;
		int          last_idx;
		result_t     fire;
		if (word.command == CMD_ADD) begin
			if (word.task_id < NUM_TASKS) begin
				task_live[word.task_id]    = 1'b1;
				task_period[word.task_id]  = 32'(word.period);
				task_elapsed[word.task_id] = 0;
				place_task(32'(word.task_id), 32'(word.period));
			end
			return;
		end
		wheel_pos = (wheel_pos + 1) % WHEEL_SLOTS;
		foreach (fired[i]) fired[i] = 1'b0;
		// wrap: overflow tasks age by a whole revolution
		if (wheel_pos == 0) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				if (!task_live[i] || !task_parked[i])
					continue;
				span = task_elapsed[i] + WHEEL_SLOTS;
				if (span == task_period[i]) begin
					fired[i]        = 1'b1;
					task_elapsed[i] = 0;
				end else begin
					task_elapsed[i] = span & 32'hFFFF;
					if (span < task_period[i] && task_period[i] - span < WHEEL_SLOTS)
						place_task(i, task_period[i] - span);
				end
			end
		end
		// tasks sitting in the current slot fire and are re-armed
		for (int i = 0; i < NUM_TASKS; i++) begin
			if (!task_live[i] || task_parked[i] || fired[i])
				continue;
			if (task_slot_at[i] != wheel_pos)
				continue;
			fired[i]        = 1'b1;
			task_elapsed[i] = 0;
			place_task(i, task_period[i]);
		end
		last_idx = -1;
		for (int i = 0; i < NUM_TASKS; i++)
			if (fired[i])
				last_idx = i;
		for (int i = 0; i < NUM_TASKS; i++) begin
			if (fired[i]) begin
				fire.fired_task = ID_W'(i);
				fire.last_fired = (i == last_idx);
				fire_queue.push_back(fire);
			end
		end
	endfunction

	function automatic void report_fail(string what, result_t want, result_t got);
		fail_count++;
		if (fail_count <= SHOWN_MISMATCHES)
			$display("%0t: %s: expected task %0d last %0b, got task %0d last %0b", $realtime,
				what, want.fired_task, want.last_fired, got.fired_task, got.last_fired);
	endfunction

	function automatic void check_fire(result_t got);
		result_t want;
		if (fire_queue.size() == 0) begin
			want = '0;
			report_fail("result word with nothing due", want, got);
			return;
		end
		want = fire_queue.pop_front();
		if (got.fired_task !== want.fired_task)
			report_fail("fired_task mismatch", want, got);
		else if (got.last_fired !== want.last_fired)
			report_fail("last_fired mismatch", want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_pos = 0;
			foreach (task_live[i]) task_live[i] = 1'b0;
			fire_queue.delete();
			fail_count    = 0;
			fires_pending = 0;
		end else begin
			if (result_valid)
				check_fire(result);
			if (start && !busy)
				predict_fires(request);
			fires_pending = fire_queue.size();
		end
	end

endmodule

### verif/timing_wheel_task_scheduler_top_tb.sv
// testbench top for the timing wheel scheduler: clock, reset, command words, verdict
// depends on twts_pkg, timing_wheel_task_scheduler_top and timing_wheel_task_scheduler_checker
module timing_wheel_task_scheduler_top_tb;
	import twts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WHEEL_SLOTS  = 64;
	localparam int NUM_TASKS    = 16;
	localparam int RESET_CYCLES = 8;
	// a tick walks every task entry, then drains the pipeline and the flush state
	localparam int DRAIN_CYCLES = NUM_TASKS + 8;
	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_WORDS = 200;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	request_t request;
	logic     busy;
	logic     result_valid;
	result_t  result;
	int       fail_count;
	int       fires_pending;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	timing_wheel_task_scheduler_top #(
		.WHEEL_SLOTS(WHEEL_SLOTS),
		.NUM_TASKS  (NUM_TASKS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.request     (request),
		.busy        (busy),
		.result_valid(result_valid),
		.result      (result)
	);

	// watches both channels, predicts the fired tasks and counts mismatches
	timing_wheel_task_scheduler_checker #(
		.WHEEL_SLOTS(WHEEL_SLOTS),
		.NUM_TASKS  (NUM_TASKS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.fail_count   (fail_count),
		.fires_pending(fires_pending)
	);

	// add word for one task
	function automatic request_t add_word(logic [ID_W-1:0] id, logic [PERIOD_W-1:0] per);
		request_t word;
		word.command = CMD_ADD;
		word.task_id = id;
		word.period  = per;
		return word;
	endfunction

	// tick word; id and period are don't-care, so they carry random bits
	function automatic request_t tick_word();
		request_t word;
		word.command = CMD_TICK;
		word.task_id = ID_W'($urandom_range(0, 15));
		word.period  = PERIOD_W'($urandom_range(0, 65535));
		return word;
	endfunction

	// holds start high until the scheduler takes the word
	task automatic issue(request_t word);
		start   <= 1'b1;
		request <= word;
		do @(posedge clk); while (busy);
	endtask

	// sender goes quiet for a number of cycles
	task automatic hold_off(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// sender waits until every fired word that is due has come out
	task automatic wait_for_fires();
		start <= 1'b0;
		do @(negedge clk); while (fires_pending != 0);
		@(posedge clk);
	endtask

	// random period: mostly inside the wheel, some overflow, a few anywhere
	function automatic logic [PERIOD_W-1:0] pick_period();
		case ($urandom_range(0, 9))
			0:       return '0;
			1, 2, 3,
			4:       return PERIOD_W'($urandom_range(1, WHEEL_SLOTS - 1));
			5, 6,
			7:       return PERIOD_W'($urandom_range(WHEEL_SLOTS, 3 * WHEEL_SLOTS));
			8:       return PERIOD_W'($urandom_range(3 * WHEEL_SLOTS + 1, 1000));
			default: return PERIOD_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// no progress on either channel for too long means the block hung
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || result_valid)
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int       words_sent;
		bit       steady;
		request_t word;
		arst_n  = 1'b0;
		start   <= 1'b0;
		request <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: period extremes, shared slot, overflow boundary, re-adds
		issue(add_word(4'd0, 16'd0));        // zero period: current slot, full revolution
		issue(add_word(4'd1, 16'd1));
		issue(add_word(4'd5, 16'd1));        // same slot as task 1, ascending order
		issue(add_word(4'd2, PERIOD_W'(WHEEL_SLOTS - 1)));
		issue(add_word(4'd3, PERIOD_W'(WHEEL_SLOTS)));  // smallest overflow period
		issue(add_word(4'd15, 16'hFFFF));    // largest period, top id
		issue(add_word(4'd4, 16'd100));      // overflow that drops back into the wheel
		issue(add_word(4'd6, 16'd130));
		issue(add_word(4'd7, PERIOD_W'(WHEEL_SLOTS + 1)));
		issue(tick_word());
		issue(tick_word());
		issue(add_word(4'd1, 16'd2));        // re-place a live task
		issue(tick_word());
		issue(tick_word());
		// let the scheduler drain before the next word
		wait_for_fires();
		issue(add_word(4'd8, 16'd0));
		issue(tick_word());
		issue(add_word(4'd9, 16'h5555));
		issue(add_word(4'd10, 16'hAAAA));
		issue(add_word(4'd14, 16'd3));
		issue(tick_word());
		issue(tick_word());
		issue(tick_word());

		// random: mostly ticks so the wheel wraps
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			steady = (words_sent >= 60 && words_sent < 110);
			if (!steady && $urandom_range(0, 99) < 29)
				hold_off($urandom_range(1, NUM_TASKS + 6));
			if (words_sent == 150)
				wait_for_fires();
			if ($urandom_range(0, 9) < 7)
				word = tick_word();
			else
				word = add_word(ID_W'($urandom_range(0, 15)), pick_period());
			issue(word);
			words_sent++;
		end

		// drain: everything due must arrive, then give the last tick time to finish
		wait_for_fires();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && fires_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### timing_wheel_task_scheduler_top.f
+incdir+design
design/twts_pkg.sv
design/timing_wheel_task_scheduler_top.sv
verif/timing_wheel_task_scheduler_checker.sv
verif/timing_wheel_task_scheduler_top_tb.sv
